// ----- src/cpso_pkg.sv -----
// cpso_pkg: shared constants and types for the convex polygon SAT overlap block.
// No dependencies; used by cpso_dot and convex_polygon_sat_overlap.
`timescale 1ns / 1ps

package cpso_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_VERTS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  // Width of the coordinate fields on the input port
  localparam int FIELD_BITS = 16;

  // Vertex kind codes on the input port
  localparam logic KIND_REF   = 1'b0;
  localparam logic KIND_OTHER = 1'b1;

  // Projection phase: which polygon a streamed vertex belongs to
  localparam logic PHASE_REF   = 1'b0;
  localparam logic PHASE_OTHER = 1'b1;

  // Tag that travels with a vertex through the dot-product pipeline
  typedef struct packed {
    logic valid;
    logic phase;
    logic first;
  } cpso_tag_t;

endpackage

// ----- src/cpso_dot.sv -----
// cpso_dot: shared two-stage dot-product unit, q = x*ax + y*ay, exact.
// Depends on cpso_pkg (cpso_tag_t).
`timescale 1ns / 1ps

module cpso_dot #(
  parameter int CW = cpso_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [CW-1:0]    x,
  input  logic signed [CW-1:0]    y,
  input  logic signed [CW:0]      ax,
  input  logic signed [CW:0]      ay,
  input  cpso_pkg::cpso_tag_t     tag_in,
  output logic signed [2*CW+1:0]  q,
  output cpso_pkg::cpso_tag_t     tag_out,
  output logic                    busy
);

  logic signed [2*CW:0] px;
  logic signed [2*CW:0] py;
  cpso_pkg::cpso_tag_t  tag_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s1  <= '0;
      tag_out <= '0;
    end else begin
      tag_s1  <= tag_in;
      tag_out <= tag_s1;
    end
  end

  // stage 1: product pair, stage 2: sum
  always_ff @(posedge clk) begin
    px <= x * ax;
    py <= y * ay;
    q  <= {px[2*CW], px} + {py[2*CW], py};
  end

  assign busy = tag_s1.valid;

endmodule

// ----- src/convex_polygon_sat_overlap.sv -----
// convex_polygon_sat_overlap: one-sided separating-axis overlap test, 2-D convex polygons.
// Depends on cpso_pkg and cpso_dot.
`timescale 1ns / 1ps
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  input   | in_valid / in_ready   | kind, point_x, point_y, last
//  output  | out_valid / out_ready | overlap, dropped
//
// The transfer with kind = other and last = 1 starts the test; in_ready stays low
// until the result sits in the output register. Per reference edge: axis fetch,
// one vertex per cycle through the shared multiply pair, pipeline drain and
// interval compare. A pass over the reference edges ends early on the first
// separating axis.
// Reset clears counts, drop flag, sequencer and output valid; vertex stores are
// not cleared. A stalled output holds the sequencer only at the final hand-off.

module convex_polygon_sat_overlap #(
  parameter int MAX_VERTS  = cpso_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = cpso_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic signed [cpso_pkg::FIELD_BITS-1:0] point_x,
  input  logic signed [cpso_pkg::FIELD_BITS-1:0] point_y,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  overlap,
  output logic                                  dropped
);

  // Effective coordinate width: reduction below the field width, never wider
  localparam int CW   = (COORD_BITS < cpso_pkg::FIELD_BITS) ? COORD_BITS
                                                             : cpso_pkg::FIELD_BITS;
  localparam int AW   = $clog2(MAX_VERTS);
  localparam int CNTW = $clog2(MAX_VERTS + 1);
  localparam int PW   = 2 * CW + 2;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // taking vertices
  localparam logic [2:0] S_RDA   = 3'd1;  // fetch edge start vertex
  localparam logic [2:0] S_RDB   = 3'd2;  // fetch edge end vertex
  localparam logic [2:0] S_AXIS  = 3'd3;  // form edge normal
  localparam logic [2:0] S_PROJ  = 3'd4;  // stream both polygons through the dot unit
  localparam logic [2:0] S_DRAIN = 3'd5;  // wait for pipeline to empty
  localparam logic [2:0] S_CMP   = 3'd6;  // interval compare
  localparam logic [2:0] S_DONE  = 3'd7;  // load output register

  logic [2:0]      state;
  logic [AW-1:0]   a;
  logic [AW-1:0]   p;
  logic            phase;
  logic [CNTW-1:0] ref_count;
  logic [CNTW-1:0] other_count;
  logic            drop_seen;
  logic            ov_result;

  // Vertex stores, {x, y} per entry
  logic [2*CW-1:0] ref_mem   [MAX_VERTS];
  logic [2*CW-1:0] other_mem [MAX_VERTS];
  logic [2*CW-1:0] ref_rdata;
  logic [2*CW-1:0] other_rdata;
  logic            ref_rd_en;
  logic            other_rd_en;
  logic [AW-1:0]   ref_raddr;

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic                 in_fire;
  logic                 ref_full;
  logic                 other_full;

  logic signed [CW-1:0] xa;
  logic signed [CW-1:0] ya;
  logic signed [CW-1:0] xb;
  logic signed [CW-1:0] yb;
  logic signed [CW:0]   ax;
  logic signed [CW:0]   ay;

  logic [AW-1:0]   b_idx;
  logic            a_last;
  logic            p_last;

  cpso_pkg::cpso_tag_t rd_tag;
  cpso_pkg::cpso_tag_t dot_tag;
  logic                dot_busy;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [PW-1:0] q;

  logic signed [PW-1:0] lo1;
  logic signed [PW-1:0] hi1;
  logic signed [PW-1:0] lo2;
  logic signed [PW-1:0] hi2;
  logic                 sep;

  // Input side
  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cx         = point_x[CW-1:0];
  assign cy         = point_y[CW-1:0];
  assign ref_full   = (ref_count == CNTW'(MAX_VERTS));
  assign other_full = (other_count == CNTW'(MAX_VERTS));

  // Edge a -> b wraps at the reference count
  assign a_last = ((CNTW'(a) + CNTW'(1)) == ref_count);
  assign b_idx  = a_last ? '0 : AW'(a + AW'(1));
  assign p_last = ((CNTW'(p) + CNTW'(1)) ==
                   ((phase == cpso_pkg::PHASE_OTHER) ? other_count : ref_count));

  always_comb begin
    case (state)
      S_RDA:   ref_raddr = a;
      S_RDB:   ref_raddr = b_idx;
      default: ref_raddr = p;
    endcase
  end

  assign ref_rd_en   = (state == S_RDA) || (state == S_RDB) ||
                       ((state == S_PROJ) && (phase == cpso_pkg::PHASE_REF));
  assign other_rd_en = (state == S_PROJ) && (phase == cpso_pkg::PHASE_OTHER);

  // Memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (in_fire && (kind == cpso_pkg::KIND_REF) && !ref_full) begin
      ref_mem[ref_count[AW-1:0]] <= {cx, cy};
    end
    if (ref_rd_en) begin
      ref_rdata <= ref_mem[ref_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (kind == cpso_pkg::KIND_OTHER) && !other_full) begin
      other_mem[other_count[AW-1:0]] <= {cx, cy};
    end
    if (other_rd_en) begin
      other_rdata <= other_mem[p];
    end
  end

  assign xb = ref_rdata[2*CW-1:CW];
  assign yb = ref_rdata[CW-1:0];

  // Vertex feed into the shared dot unit
  assign dx = (rd_tag.phase == cpso_pkg::PHASE_OTHER) ? other_rdata[2*CW-1:CW]
                                                      : ref_rdata[2*CW-1:CW];
  assign dy = (rd_tag.phase == cpso_pkg::PHASE_OTHER) ? other_rdata[CW-1:0]
                                                      : ref_rdata[CW-1:0];

  cpso_dot #(
    .CW (CW)
  ) u_dot (
    .clk     (clk),
    .rst     (rst),
    .x       (dx),
    .y       (dy),
    .ax      (ax),
    .ay      (ay),
    .tag_in  (rd_tag),
    .q       (q),
    .tag_out (dot_tag),
    .busy    (dot_busy)
  );

  // Intervals touch or overlap unless one lies wholly beyond the other
  assign sep = !((hi2 >= lo1) && (hi1 >= lo2));

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      a           <= '0;
      p           <= '0;
      phase       <= cpso_pkg::PHASE_REF;
      ref_count   <= '0;
      other_count <= '0;
      drop_seen   <= 1'b0;
      ov_result   <= 1'b0;
      out_valid   <= 1'b0;
      rd_tag      <= '0;
    end else begin
      // tag rides along with the read issued this cycle
      if (state == S_PROJ) begin
        rd_tag.valid <= 1'b1;
        rd_tag.phase <= phase;
        rd_tag.first <= (p == '0);
      end else begin
        rd_tag <= '0;
      end
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (kind == cpso_pkg::KIND_REF) begin
              if (!ref_full) begin
                ref_count <= ref_count + CNTW'(1);
              end else begin
                drop_seen <= 1'b1;
              end
            end else begin
              if (!other_full) begin
                other_count <= other_count + CNTW'(1);
              end else begin
                drop_seen <= 1'b1;
              end
              if (last) begin
                a <= '0;
                if (ref_count == '0) begin
                  // no reference edge, nothing can separate
                  ov_result <= 1'b1;
                  state     <= S_DONE;
                end else begin
                  state <= S_RDA;
                end
              end
            end
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          state <= S_AXIS;
        end
        S_AXIS: begin
          phase <= cpso_pkg::PHASE_REF;
          p     <= '0;
          state <= S_PROJ;
        end
        S_PROJ: begin
          if (p_last) begin
            p <= '0;
            if (phase == cpso_pkg::PHASE_OTHER) begin
              state <= S_DRAIN;
            end else begin
              phase <= cpso_pkg::PHASE_OTHER;
            end
          end else begin
            p <= p + AW'(1);
          end
        end
        S_DRAIN: begin
          if (!rd_tag.valid && !dot_busy && !dot_tag.valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (sep) begin
            ov_result <= 1'b0;
            state     <= S_DONE;
          end else if (a_last) begin
            ov_result <= 1'b1;
            state     <= S_DONE;
          end else begin
            a     <= a + AW'(1);
            state <= S_RDA;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            overlap     <= ov_result;
            dropped     <= drop_seen;
            ref_count   <= '0;
            other_count <= '0;
            drop_seen   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_RDB) begin
      xa <= xb;  // read data here is the edge start vertex
      ya <= yb;
    end
    if (state == S_AXIS) begin
      // normal of edge a -> b: (-(yb - ya), xb - xa)
      ax <= {ya[CW-1], ya} - {yb[CW-1], yb};
      ay <= {xb[CW-1], xb} - {xa[CW-1], xa};
    end
    if (dot_tag.valid) begin
      if (dot_tag.phase == cpso_pkg::PHASE_REF) begin
        lo1 <= (dot_tag.first || (q < lo1)) ? q : lo1;
        hi1 <= (dot_tag.first || (q > hi1)) ? q : hi1;
      end else begin
        lo2 <= (dot_tag.first || (q < lo2)) ? q : lo2;
        hi2 <= (dot_tag.first || (q > hi2)) ? q : hi2;
      end
    end
  end

endmodule

// ----- src/cpso_checker.sv -----
// cpso_checker: port-level assertions for convex_polygon_sat_overlap, plus its bind.
// Depends on convex_polygon_sat_overlap (bind target).
`timescale 1ns / 1ps

module cpso_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic kind,
  input logic last,
  input logic out_valid,
  input logic out_ready,
  input logic overlap,
  input logic dropped
);

  // A test-starting transfer closes the input; only the sample right after it is checked
  a_test_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind && last) |=> !in_ready)
    else $error("input still ready after test start");

  // A result only appears after the block was busy with a test
  a_result_after_test: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a preceding test");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(overlap) && $stable(dropped)))
    else $error("stalled result changed or vanished");

  // A reference vertex never produces a result transfer on its own
  a_ref_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !kind && !out_valid) |=> !out_valid)
    else $error("result after reference vertex");

endmodule

bind convex_polygon_sat_overlap cpso_checker u_cpso_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .kind      (kind),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .overlap   (overlap),
  .dropped   (dropped)
);
